// ===== hdl/ste_pkg.sv =====
package ste_pkg;

    // attribute byte size codes (bits 4:2)
    localparam logic [2:0] SIZE_32X32 = 3'b100;
    localparam logic [2:0] SIZE_16X32 = 3'b010;
    localparam logic [2:0] SIZE_32X16 = 3'b001;

    // screen flip mirrors about this origin
    localparam logic [10:0] FLIP_ORIGIN = 11'd240;
    // extra offset for flipped 32x32 sprites, also one tile step
    localparam logic [10:0] TILE_STEP = 11'd16;

    // one decoded sprite entry, as queued for the back end
    typedef struct packed {
        logic [10:0]        number;
        logic [3:0]         color;
        logic               flip_x;
        logic               flip_y;
        logic signed [10:0] pos_x;
        logic signed [9:0]  pos_y;
        logic               wide;
        logic               tall;
        logic               gset;
        logic               fin;
    } entry_t;

endpackage

// ===== hdl/ste_front.sv =====
module ste_front
(
    input  logic [7:0]      number_low,
    input  logic [7:0]      bank_and_color,
    input  logic [7:0]      y_byte,
    input  logic [7:0]      x_byte,
    input  logic [7:0]      attribute_byte,
    input  logic            flip_screen,
    input  logic            graphics_set,
    input  logic            final_entry,
    output ste_pkg::entry_t entry
);

    logic [10:0] number_raw;
    logic [2:0]  size_code;
    logic        big;
    logic [10:0] x_raw;
    logic [10:0] y_raw;
    logic [10:0] big_off;
    logic [10:0] x_flip;
    logic [10:0] y_flip;

    assign number_raw = {bank_and_color[2:0], number_low};
    assign size_code  = attribute_byte[4:2];
    assign big        = (size_code == ste_pkg::SIZE_32X32);
    assign x_raw      = {2'b00, attribute_byte[0], x_byte};
    assign y_raw      = {3'b000, y_byte};
    assign big_off    = big ? ste_pkg::TILE_STEP : 11'd0;
    assign x_flip     = ste_pkg::FLIP_ORIGIN - x_raw - big_off;
    assign y_flip     = ste_pkg::FLIP_ORIGIN - y_raw - big_off;

    // size decode, number alignment and screen flip
    always_comb
    begin
        entry        = '0;
        entry.color  = bank_and_color[7:4];
        entry.flip_x = attribute_byte[5] ^ flip_screen;
        entry.flip_y = attribute_byte[6] ^ flip_screen;
        entry.pos_x  = flip_screen ? x_flip : x_raw;
        entry.pos_y  = flip_screen ? y_flip[9:0] : y_raw[9:0];
        entry.gset   = graphics_set;
        entry.fin    = final_entry;
        unique case (size_code)
            ste_pkg::SIZE_32X32:
            begin
                entry.number = {number_raw[10:2], 2'b00};
                entry.wide   = 1'b1;
                entry.tall   = 1'b1;
            end
            ste_pkg::SIZE_16X32:
            begin
                entry.number = {number_raw[10:2], 1'b0, number_raw[0]};
                entry.wide   = 1'b0;
                entry.tall   = 1'b1;
            end
            ste_pkg::SIZE_32X16:
            begin
                entry.number = {number_raw[10:1], 1'b0};
                entry.wide   = 1'b1;
                entry.tall   = 1'b0;
            end
            default:
            begin
                entry.number = number_raw;
                entry.wide   = 1'b0;
                entry.tall   = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/ste_queue.sv =====
module ste_queue #(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ste_pkg::entry_t push_data,
    input  logic            pop,
    output ste_pkg::entry_t pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ste_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/ste_back.sv =====
module ste_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  ste_pkg::entry_t    q_data,
    output logic               q_pop,
    output logic               strobe,
    output logic [10:0]        tile_code,
    output logic [3:0]         palette_color,
    output logic               mirror_x,
    output logic               mirror_y,
    output logic signed [10:0] screen_x,
    output logic signed [9:0]  screen_y,
    output logic               graphics_select,
    output logic               last_of_entry,
    output logic               list_end
);

    ste_pkg::entry_t    cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic               col_reg, col_next;
    logic               row_reg, row_next;
    logic               strobe_reg;
    logic [10:0]        code_reg;
    logic [3:0]         color_reg;
    logic               mx_reg, my_reg;
    logic signed [10:0] sx_reg;
    logic signed [9:0]  sy_reg;
    logic               gsel_reg, last_reg, lend_reg;

    logic               ex, ey, tile_last;
    logic [10:0]        code_calc;
    logic [10:0]        px_calc;
    logic [9:0]         py_calc;

    // tile of the current entry at (col, row)
    assign ex        = col_reg ^ (cur_reg.flip_x & cur_reg.wide);
    assign ey        = row_reg ^ (cur_reg.flip_y & cur_reg.tall);
    assign tile_last = (col_reg == cur_reg.wide) && (row_reg == cur_reg.tall);
    assign code_calc = cur_reg.number + {9'd0, ey, ex};
    assign px_calc   = cur_reg.pos_x + {6'd0, col_reg, 4'd0};
    assign py_calc   = cur_reg.pos_y + {5'd0, row_reg, 4'd0};

    // take the next entry when idle or on the last tile
    assign q_pop = !q_empty && (!cur_valid_reg || tile_last);

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        if (cur_valid_reg && !tile_last)
        begin
            if (col_reg != cur_reg.wide)
            begin
                col_next = 1'b1;
            end
            else
            begin
                col_next = 1'b0;
                row_next = 1'b1;
            end
        end
        else
        begin
            col_next       = 1'b0;
            row_next       = 1'b0;
            cur_valid_next = q_pop;
            if (q_pop)
            begin
                cur_next = q_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            col_reg       <= 1'b0;
            row_reg       <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            strobe_reg    <= cur_valid_reg;
        end
    end

    // entry and result registers, no reset
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cur_valid_reg)
        begin
            code_reg  <= code_calc;
            color_reg <= cur_reg.color;
            mx_reg    <= cur_reg.flip_x;
            my_reg    <= cur_reg.flip_y;
            sx_reg    <= px_calc;
            sy_reg    <= py_calc;
            gsel_reg  <= cur_reg.gset;
            last_reg  <= tile_last;
            lend_reg  <= tile_last & cur_reg.fin;
        end
    end

    assign strobe          = strobe_reg;
    assign tile_code       = code_reg;
    assign palette_color   = color_reg;
    assign mirror_x        = mx_reg;
    assign mirror_y        = my_reg;
    assign screen_x        = sx_reg;
    assign screen_y        = sy_reg;
    assign graphics_select = gsel_reg;
    assign last_of_entry   = last_reg;
    assign list_end        = lend_reg;

endmodule

// ===== hdl/sprite_entry_tile_expander.sv =====
// Channel   Ports                                   Transfer
// entry     number_low .. final_entry               start high, busy low
// tile      tile_code .. list_end                   strobe high, one cycle
//
// An entry gives 1, 2 or 4 tiles; the tile sequencer emits one tile per cycle
// while entries are queued, so the sustained entry rate is set by the tile count.
// The first tile passes the entry queue, the current-entry register and the output registers.
// busy rises when the entry queue (QUEUE_DEPTH entries) is full.
// rst_n clears the queue and sequencer; no clearing pass.
// Tiles cannot be held off: strobe marks each one for exactly one cycle.
module sprite_entry_tile_expander #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         number_low,
    input  logic [7:0]         bank_and_color,
    input  logic [7:0]         y_byte,
    input  logic [7:0]         x_byte,
    input  logic [7:0]         attribute_byte,
    input  logic               flip_screen,
    input  logic               graphics_set,
    input  logic               final_entry,
    output logic               strobe,
    output logic [10:0]        tile_code,
    output logic [3:0]         palette_color,
    output logic               mirror_x,
    output logic               mirror_y,
    output logic signed [10:0] screen_x,
    output logic signed [9:0]  screen_y,
    output logic               graphics_select,
    output logic               last_of_entry,
    output logic               list_end
);

    ste_pkg::entry_t dec_entry;
    ste_pkg::entry_t q_data;
    logic            q_full, q_empty, q_pop, push;

    assign busy = q_full;
    assign push = start && !q_full;

    // entry decode
    ste_front u_front
    (
        .number_low     (number_low),
        .bank_and_color (bank_and_color),
        .y_byte         (y_byte),
        .x_byte         (x_byte),
        .attribute_byte (attribute_byte),
        .flip_screen    (flip_screen),
        .graphics_set   (graphics_set),
        .final_entry    (final_entry),
        .entry          (dec_entry)
    );

    // decoded entry queue
    ste_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (dec_entry),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // tile sequencer
    ste_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .strobe          (strobe),
        .tile_code       (tile_code),
        .palette_color   (palette_color),
        .mirror_x        (mirror_x),
        .mirror_y        (mirror_y),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .graphics_select (graphics_select),
        .last_of_entry   (last_of_entry),
        .list_end        (list_end)
    );

    // tiles of one entry come out in consecutive cycles
    a_tiles_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_of_entry |=> strobe)
        else $error("gap inside an entry's tile burst");

    // list end only on the last tile of an entry
    a_list_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && list_end |-> last_of_entry)
        else $error("list_end without last_of_entry");

    // an empty queue is never popped
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("pop from empty entry queue");

endmodule
